// ===== rtl/core/sotl_pkg.sv =====
// shared types, codes and helpers of the sparse octree cell lookup
package sotl_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int LEVELS_DEF   = 16;
    localparam int IDX_W        = 10;
    localparam int NORM_W       = 25;
    localparam int MORTON_W     = 48;
    localparam int KEY_W        = 52;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_OOB      = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [2:0] REG_MIN_X   = 3'd0;
    localparam logic [2:0] REG_MIN_Y   = 3'd1;
    localparam logic [2:0] REG_MIN_Z   = 3'd2;
    localparam logic [2:0] REG_INV_X   = 3'd3;
    localparam logic [2:0] REG_INV_Y   = 3'd4;
    localparam logic [2:0] REG_INV_Z   = 3'd5;
    localparam logic [2:0] REG_FIRST   = 3'd6;
    localparam logic [2:0] REG_LAST    = 3'd7;

    localparam logic [31:0] INV_ONE = 32'h0100_0000;

    typedef struct packed {
        logic [1:0]          op;
        logic [3:0]          key_level;
        logic [MORTON_W-1:0] key_morton;
        logic [NORM_W-1:0]   nx;
        logic [NORM_W-1:0]   ny;
        logic [NORM_W-1:0]   nz;
        logic                oob;
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LVL,
        B_RD,
        B_CMP,
        B_OUT
    } back_state_t;

    function automatic logic [MORTON_W-1:0] interleave3(
        input logic [15:0] x,
        input logic [15:0] y,
        input logic [15:0] z
    );
        logic [MORTON_W-1:0] m;
        m = '0;
        for (int b = 0; b < 16; b++)
        begin
            m[3*b]   = x[b];
            m[3*b+1] = y[b];
            m[3*b+2] = z[b];
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/sotl_front.sv =====
// front end: takes items, normalizes query positions, hands commands on
module sotl_front import sotl_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          operation,
    input  logic [3:0]          key_level,
    input  logic [MORTON_W-1:0] key_morton,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  min_x,
    input  logic signed [31:0]  min_y,
    input  logic signed [31:0]  min_z,
    input  logic [31:0]         inv_x,
    input  logic [31:0]         inv_y,
    input  logic [31:0]         inv_z,
    output logic                q_push,
    output cmd_t                q_cmd,
    input  logic                q_full
);

    front_state_t state_reg, state_next;
    logic [2:0]   step_reg;
    logic [1:0]   op_reg;
    logic [3:0]   lvl_reg;
    logic [MORTON_W-1:0] mort_reg;
    logic [32:0]  d_reg [3];
    logic [31:0]  inv_reg [3];
    logic [NORM_W-1:0] n_reg [3];
    logic         oob_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   mul_ax;
    logic [1:0]   ev_ax;
    logic [47:0]  n_full;
    logic         ev_bad;

    assign full   = (state_reg != F_IDLE);
    assign mul_ax = (step_reg < 3'd3) ? step_reg[1:0] : 2'd0;
    assign ev_ax  = (step_reg != 3'd0) ? 2'(step_reg - 3'd1) : 2'd0;
    assign n_full = prod_reg[63:16];
    assign ev_bad = d_reg[ev_ax][32] || (inv_reg[ev_ax] == 32'd0)
                    || (n_full > 48'h100_0000);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (push && operation != OP_NONE)
                    state_next = (operation == OP_QUERY) ? F_CALC : F_PUSH;
            end
            F_CALC:
            begin
                if (step_reg == 3'd3)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        q_push           = (state_reg == F_PUSH) && !q_full;
        q_cmd.op         = op_reg;
        q_cmd.key_level  = lvl_reg;
        q_cmd.key_morton = mort_reg;
        q_cmd.nx         = n_reg[0];
        q_cmd.ny         = n_reg[1];
        q_cmd.nz         = n_reg[2];
        q_cmd.oob        = oob_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            op_reg     <= operation;
            lvl_reg    <= key_level;
            mort_reg   <= key_morton;
            d_reg[0]   <= 33'(pos_x) - 33'(min_x);
            d_reg[1]   <= 33'(pos_y) - 33'(min_y);
            d_reg[2]   <= 33'(pos_z) - 33'(min_z);
            inv_reg[0] <= inv_x;
            inv_reg[1] <= inv_y;
            inv_reg[2] <= inv_z;
            oob_reg    <= 1'b0;
            step_reg   <= 3'd0;
            n_reg[0]   <= '0;
            n_reg[1]   <= '0;
            n_reg[2]   <= '0;
        end
        else if (state_reg == F_CALC)
        begin
            prod_reg <= d_reg[mul_ax][31:0] * inv_reg[mul_ax];
            if (step_reg != 3'd0)
            begin
                n_reg[ev_ax] <= n_full[NORM_W-1:0];
                if (ev_bad)
                    oob_reg <= 1'b1;
            end
            step_reg <= step_reg + 3'd1;
        end
    end

endmodule

// ===== rtl/core/sotl_queue.sv =====
// two-entry command queue between front and back
module sotl_queue import sotl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic q_empty
);

    cmd_t       slot_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign rd_cmd  = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 2'd1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wp_reg] <= wr_cmd;
    end

endmodule

// ===== rtl/core/sotl_back.sv =====
// back end: key store, level walk with store scan, result register
module sotl_back import sotl_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LEVELS   = LEVELS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    input  logic [3:0]       first_level,
    input  logic [3:0]       last_level,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       status,
    output logic [3:0]       cell_level,
    output logic [15:0]      cell_x,
    output logic [15:0]      cell_y,
    output logic [15:0]      cell_z,
    output logic [IDX_W-1:0] cell_index
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    back_state_t state_reg, state_next;
    logic [KEY_W-1:0]  mem [CAPACITY];
    logic [KEY_W-1:0]  rdata_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     scan_reg;
    logic [3:0]        lvl_reg;
    logic [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [15:0]       cx_reg, cy_reg, cz_reg;
    logic [1:0]        pst_reg;
    logic [3:0]        plvl_reg;
    logic [15:0]       pcx_reg, pcy_reg, pcz_reg;
    logic [IDX_W-1:0]  pidx_reg;
    logic              ovalid_reg;
    logic              out_load;
    logic              mem_we;
    logic [15:0]       cx_c, cy_c, cz_c;
    logic              lvl_skip;
    logic              lvl_last;
    logic              scan_end;
    logic              hit;
    logic [31:0]       cnt_w, scan_w;

    function automatic logic [15:0] cell_coord(
        input logic [NORM_W-1:0] n,
        input logic [3:0]        lvl
    );
        logic [4:0]        sh;
        logic [NORM_W-1:0] cf;
        logic [NORM_W-1:0] res;
        sh  = 5'd24 - {1'b0, lvl};
        cf  = n >> sh;
        res = NORM_W'(1) << lvl;
        if (cf >= res)
            cf = res - NORM_W'(1);
        return cf[15:0];
    endfunction

    assign cx_c     = cell_coord(nx_reg, lvl_reg);
    assign cy_c     = cell_coord(ny_reg, lvl_reg);
    assign cz_c     = cell_coord(nz_reg, lvl_reg);
    assign lvl_skip = ({1'b0, lvl_reg} >= 5'(LEVELS));
    assign lvl_last = (lvl_reg == first_level) || (lvl_reg == 4'd0);
    assign scan_end = (scan_reg + CW'(1) == cnt_reg);
    assign hit      = (rdata_reg == key_reg);
    assign cnt_w    = 32'(cnt_reg);
    assign scan_w   = 32'(scan_reg);

    assign empty      = !ovalid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_cmd.op == OP_QUERY && cnt_reg != '0 && !q_cmd.oob
                        && first_level <= last_level)
                        state_next = B_LVL;
                    else
                        state_next = B_OUT;
                end
            end
            B_LVL:
            begin
                if (!lvl_skip)
                    state_next = B_RD;
                else if (lvl_last)
                    state_next = B_OUT;
            end
            B_RD:  state_next = B_CMP;
            B_CMP:
            begin
                if (hit)
                    state_next = B_OUT;
                else if (scan_end)
                    state_next = lvl_last ? B_OUT : B_LVL;
                else
                    state_next = B_RD;
            end
            B_OUT:
            begin
                if (!ovalid_reg || pop)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop    = (state_reg == B_IDLE) && !q_empty;
        mem_we   = q_pop && (q_cmd.op == OP_APPEND) && (cnt_reg < CW'(CAPACITY));
        out_load = (state_reg == B_OUT) && (!ovalid_reg || pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && q_cmd.op == OP_CLEAR)
                cnt_reg <= '0;
            else if (mem_we)
                cnt_reg <= cnt_reg + CW'(1);
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (pop)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[cnt_reg[AW-1:0]] <= {q_cmd.key_level, q_cmd.key_morton};
        if (state_reg == B_RD)
            rdata_reg <= mem[scan_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                pst_reg  <= ST_OK;
                plvl_reg <= '0;
                pcx_reg  <= '0;
                pcy_reg  <= '0;
                pcz_reg  <= '0;
                pidx_reg <= '0;
                nx_reg   <= q_cmd.nx;
                ny_reg   <= q_cmd.ny;
                nz_reg   <= q_cmd.nz;
                lvl_reg  <= last_level;
                if (q_cmd.op == OP_APPEND)
                begin
                    if (cnt_reg >= CW'(CAPACITY))
                        pst_reg <= ST_FULL;
                    else
                        pidx_reg <= cnt_w[IDX_W-1:0];
                end
                else if (q_cmd.op == OP_QUERY)
                begin
                    if (cnt_reg == '0)
                        pst_reg <= ST_NOTFOUND;
                    else if (q_cmd.oob)
                        pst_reg <= ST_OOB;
                    else
                        pst_reg <= ST_NOTFOUND;
                end
            end
            B_LVL:
            begin
                cx_reg   <= cx_c;
                cy_reg   <= cy_c;
                cz_reg   <= cz_c;
                key_reg  <= {lvl_reg, interleave3(cx_c, cy_c, cz_c)};
                scan_reg <= '0;
                if (lvl_skip && !lvl_last)
                    lvl_reg <= lvl_reg - 4'd1;
            end
            B_CMP:
            begin
                if (hit)
                begin
                    pst_reg  <= ST_OK;
                    plvl_reg <= lvl_reg;
                    pcx_reg  <= cx_reg;
                    pcy_reg  <= cy_reg;
                    pcz_reg  <= cz_reg;
                    pidx_reg <= scan_w[IDX_W-1:0];
                end
                else if (scan_end)
                begin
                    if (!lvl_last)
                        lvl_reg <= lvl_reg - 4'd1;
                end
                else
                    scan_reg <= scan_reg + CW'(1);
            end
            default: ;
        endcase
        if (out_load)
        begin
            status     <= pst_reg;
            cell_level <= plvl_reg;
            cell_x     <= pcx_reg;
            cell_y     <= pcy_reg;
            cell_z     <= pcz_reg;
            cell_index <= pidx_reg;
        end
    end

endmodule

// ===== rtl/core/sparse_octree_deepest_cell_lookup.sv =====
// top level of the sparse octree deepest cell lookup
// usage:
// - input channel is a queue write side: an item transfers when push is high and
//   full is low; operation selects clear, append key or query position
// - result channel is a queue read side: the oldest result sits on the ports
//   while empty is low and transfers when pop is high
// - config registers are written through cfg_we, cfg_index, cfg_data; the user must
//   write them only while idle, the block itself does not enforce this
// - clear and append pass the front end and queue to the back end, which loads the result;
//   a query is normalized first, then the back end walks the levels from last down, scanning
//   the single-port key store one key at a time at each level, stopping at the first hit
// - one item is worked on in the back end at a time; the front end and a
//   two-entry command queue take up to three more items meanwhile
// - a stalled result register holds its item; the back end waits, the
//   queue fills, then full rises
// - reset empties the key store (entry count zero), the queues and the
//   result register, and loads the register defaults; no clearing pass
module sparse_octree_deepest_cell_lookup import sotl_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LEVELS   = LEVELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          operation,
    input  logic [3:0]          key_level,
    input  logic [MORTON_W-1:0] key_morton,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          status,
    output logic [3:0]          cell_level,
    output logic [15:0]         cell_x,
    output logic [15:0]         cell_y,
    output logic [15:0]         cell_z,
    output logic [IDX_W-1:0]    cell_index,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    // configuration registers
    logic signed [31:0] min_x_reg, min_y_reg, min_z_reg;
    logic [31:0]        inv_x_reg, inv_y_reg, inv_z_reg;
    logic [3:0]         first_reg, last_reg;

    // front to back command path
    logic q_push, q_full, q_pop, q_empty;
    cmd_t wr_cmd, rd_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            min_z_reg <= '0;
            inv_x_reg <= INV_ONE;
            inv_y_reg <= INV_ONE;
            inv_z_reg <= INV_ONE;
            first_reg <= 4'd0;
            last_reg  <= 4'd15;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_X: min_x_reg <= cfg_data;
                REG_MIN_Y: min_y_reg <= cfg_data;
                REG_MIN_Z: min_z_reg <= cfg_data;
                REG_INV_X: inv_x_reg <= cfg_data;
                REG_INV_Y: inv_y_reg <= cfg_data;
                REG_INV_Z: inv_z_reg <= cfg_data;
                REG_FIRST: first_reg <= cfg_data[3:0];
                REG_LAST:  last_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // front: accepts items, bounds check and normalization of queries
    sotl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .key_level  (key_level),
        .key_morton (key_morton),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .min_x      (min_x_reg),
        .min_y      (min_y_reg),
        .min_z      (min_z_reg),
        .inv_x      (inv_x_reg),
        .inv_y      (inv_y_reg),
        .inv_z      (inv_z_reg),
        .q_push     (q_push),
        .q_cmd      (wr_cmd),
        .q_full     (q_full)
    );

    // decoupling queue
    sotl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (wr_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (rd_cmd),
        .q_empty (q_empty)
    );

    // back: store updates, level walk and result register
    sotl_back #(
        .CAPACITY (CAPACITY),
        .LEVELS   (LEVELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (rd_cmd),
        .q_pop       (q_pop),
        .first_level (first_reg),
        .last_level  (last_reg),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .cell_level  (cell_level),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_z      (cell_z),
        .cell_index  (cell_index)
    );

endmodule
